FILE: hdl/mdnrt_pkg.sv
// Shared constants and register index codes for the noise reverb tail core.
package mdnrt_pkg;

    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int COEFF_FRAC_BITS_DEF = 24;
    localparam int GUARD_BITS          = 8;
    localparam int CFG_INDEX_W         = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_LOW_COEFF        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MID_COEFF        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_COEFF_START = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_COEFF_RATIO = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_DECAY_RATIO  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MID_DECAY_RATIO  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_DECAY_RATIO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_LATE_GAIN        = 3'd7;

endpackage

FILE: hdl/multiband_decaying_noise_reverb_tail_core.sv
// Three-band decaying noise reverb tail: one shared multiplier under a small sequencer.
// Each accepted request runs 11 multiplies on the shared multiplier, each a load state then a
// multiply state, and then a done state rounds and saturates the result onto m_tdata.
// A new sample is taken only once the previous one is through the sequencer:
// s_tready is high only in idle, and a result waiting on m_tready holds the sequencer.
// Reset (rst_n low, asynchronous): defaults load, filters clear, envelopes 1.0, darkening 0.
module multiband_decaying_noise_reverb_tail_core #(
    parameter int SAMPLE_BITS     = mdnrt_pkg::SAMPLE_BITS_DEF,
    parameter int COEFF_FRAC_BITS = mdnrt_pkg::COEFF_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input sample stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,  // noise, zero padding above
    input  logic                                 s_tuser,  // restart
    // output sample stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,  // tail_sample, zero padding above
    // register write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mdnrt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [COEFF_FRAC_BITS:0]             cfg_data
);

    localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int F          = COEFF_FRAC_BITS;
    localparam int CW         = COEFF_FRAC_BITS + 1;
    localparam int STATE_BITS = SAMPLE_BITS + mdnrt_pkg::GUARD_BITS;
    // multiplier A operand: signed filter states and differences or the band sum,
    // or a zero-extended envelope / coefficient for the geometric updates
    localparam int A_W   = (STATE_BITS + 2 > CW + 1) ? STATE_BITS + 2 : CW + 1;
    localparam int P_W   = A_W + CW + 1;
    localparam int SUM_W = STATE_BITS + 3;

    localparam logic [CW-1:0] UNITY = CW'(1) << F;
    localparam logic signed [P_W-1:0] UNITY_P = P_W'(1) << F;
    localparam logic signed [P_W-1:0] HALF_F  = P_W'(1) << (F - 1);
    localparam logic signed [P_W-1:0] HALF_G  = P_W'(1) << (F + mdnrt_pkg::GUARD_BITS - 1);
    localparam logic signed [P_W-1:0] ST_MAX  = (P_W'(1) << (STATE_BITS - 1)) - P_W'(1);
    localparam logic signed [P_W-1:0] ST_MIN  = -ST_MAX - P_W'(1);
    localparam logic signed [P_W-1:0] SMP_MAX = (P_W'(1) << (SAMPLE_BITS - 1)) - P_W'(1);
    localparam logic signed [P_W-1:0] SMP_MIN = -SMP_MAX - P_W'(1);
    localparam logic signed [SUM_W-1:0] SUM_LIM = (SUM_W'(1) << (STATE_BITS + 1)) - SUM_W'(1);

    // Sequencer: each operation loads operands, then multiplies. The rounding and
    // write-back of each operation but the last happens in the load cycle of the next one, so the
    // order below keeps every operation away from the result of the one just before.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_LOW,   // low crossover one-pole
        OP_MID,   // high crossover one-pole
        OP_ENVL,  // low band times its envelope
        OP_DARK,  // darkening one-pole on the raw high band
        OP_ENVM,  // mid band times its envelope
        OP_GEOL,  // low envelope decay
        OP_ENVH,  // darkened high band times its envelope
        OP_GEOM,  // mid envelope decay
        OP_GEOH,  // high envelope decay
        OP_GEOD,  // darkening coefficient growth
        OP_GAIN   // band sum times late gain
    } op_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    op_t    post_op;

    // configuration registers
    logic [CW-1:0] low_coeff_reg, low_coeff_next;
    logic [CW-1:0] mid_coeff_reg, mid_coeff_next;
    logic [CW-1:0] high_coeff_start_reg, high_coeff_start_next;
    logic [CW-1:0] high_coeff_ratio_reg, high_coeff_ratio_next;
    logic [CW-1:0] low_decay_ratio_reg, low_decay_ratio_next;
    logic [CW-1:0] mid_decay_ratio_reg, mid_decay_ratio_next;
    logic [CW-1:0] high_decay_ratio_reg, high_decay_ratio_next;
    logic [CW-1:0] late_gain_reg, late_gain_next;

    // channel state
    logic signed [STATE_BITS-1:0] low_s_reg, low_s_next;
    logic signed [STATE_BITS-1:0] mid_s_reg, mid_s_next;
    logic signed [STATE_BITS-1:0] dark_s_reg, dark_s_next;
    logic [CW-1:0] dark_coeff_reg, dark_coeff_next;
    logic [CW-1:0] env_low_reg, env_low_next;
    logic [CW-1:0] env_mid_reg, env_mid_next;
    logic [CW-1:0] env_high_reg, env_high_next;

    // datapath
    logic signed [STATE_BITS-1:0] x_reg, x_next;
    logic signed [A_W-1:0]        a_reg, a_next;
    logic [CW-1:0]                b_reg, b_next;
    logic signed [P_W-1:0]        prod_reg;
    logic signed [SUM_W-1:0]      sum_reg, sum_next;
    logic signed [SUM_W-1:0]      sum_clamped;
    logic [SAMPLE_BITS-1:0]       tail_reg, tail_next;
    logic                         m_tvalid_reg, m_tvalid_next;

    logic signed [P_W-1:0] rnd_f;
    logic signed [P_W-1:0] rnd_g;
    logic signed [P_W-1:0] x_p;
    logic signed [P_W-1:0] high_raw_p;
    logic [CW-1:0]         geo_val;
    logic                  out_free;

    function automatic logic [CW-1:0] clamp_unity(input logic [CW-1:0] v);
        clamp_unity = (v > UNITY) ? UNITY : v;
    endfunction

    function automatic logic signed [STATE_BITS-1:0] sat_state(input logic signed [P_W-1:0] v);
        if (v > ST_MAX)
        begin
            sat_state = ST_MAX[STATE_BITS-1:0];
        end
        else if (v < ST_MIN)
        begin
            sat_state = ST_MIN[STATE_BITS-1:0];
        end
        else
        begin
            sat_state = v[STATE_BITS-1:0];
        end
    endfunction

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = TDATA_W'(tail_reg);

    assign post_op  = op_t'(op_reg - 4'd1);
    assign out_free = !m_tvalid_reg || m_tready;

    // round half up, then floor, of the last product
    assign rnd_f = (prod_reg + HALF_F) >>> F;
    assign rnd_g = (prod_reg + HALF_G) >>> (F + mdnrt_pkg::GUARD_BITS);

    assign x_p        = P_W'(x_reg);
    assign high_raw_p = P_W'(x_reg) - P_W'(mid_s_reg);
    assign geo_val    = (rnd_f > UNITY_P) ? UNITY : rnd_f[CW-1:0];

    // limit the band sum just below +/-4.0 before the gain
    assign sum_clamped = (sum_reg > SUM_LIM) ? SUM_LIM :
                         (sum_reg < -SUM_LIM) ? -SUM_LIM : sum_reg;

    always_comb
    begin
        state_next            = state_reg;
        op_next               = op_reg;
        low_coeff_next        = low_coeff_reg;
        mid_coeff_next        = mid_coeff_reg;
        high_coeff_start_next = high_coeff_start_reg;
        high_coeff_ratio_next = high_coeff_ratio_reg;
        low_decay_ratio_next  = low_decay_ratio_reg;
        mid_decay_ratio_next  = mid_decay_ratio_reg;
        high_decay_ratio_next = high_decay_ratio_reg;
        late_gain_next        = late_gain_reg;
        low_s_next            = low_s_reg;
        mid_s_next            = mid_s_reg;
        dark_s_next           = dark_s_reg;
        dark_coeff_next       = dark_coeff_reg;
        env_low_next          = env_low_reg;
        env_mid_next          = env_mid_reg;
        env_high_next         = env_high_reg;
        x_next                = x_reg;
        a_next                = a_reg;
        b_next                = b_reg;
        sum_next              = sum_reg;
        tail_next             = tail_reg;
        m_tvalid_next         = m_tvalid_reg;

        // drop the output once the consumer takes it
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                mdnrt_pkg::REG_LOW_COEFF:        low_coeff_next        = cfg_data;
                mdnrt_pkg::REG_MID_COEFF:        mid_coeff_next        = cfg_data;
                mdnrt_pkg::REG_HIGH_COEFF_START: high_coeff_start_next = cfg_data;
                mdnrt_pkg::REG_HIGH_COEFF_RATIO: high_coeff_ratio_next = cfg_data;
                mdnrt_pkg::REG_LOW_DECAY_RATIO:  low_decay_ratio_next  = cfg_data;
                mdnrt_pkg::REG_MID_DECAY_RATIO:  mid_decay_ratio_next  = cfg_data;
                mdnrt_pkg::REG_HIGH_DECAY_RATIO: high_decay_ratio_next = cfg_data;
                mdnrt_pkg::REG_LATE_GAIN:        late_gain_next        = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    x_next  = $signed({s_tdata[SAMPLE_BITS-1:0],
                                       {mdnrt_pkg::GUARD_BITS{1'b0}}});
                    op_next = OP_LOW;
                    state_next = ST_LOAD;
                    // start a new channel before this sample
                    if (s_tuser)
                    begin
                        low_s_next      = '0;
                        mid_s_next      = '0;
                        dark_s_next     = '0;
                        dark_coeff_next = clamp_unity(high_coeff_start_reg);
                        env_low_next    = UNITY;
                        env_mid_next    = UNITY;
                        env_high_next   = UNITY;
                    end
                end
            end

            ST_LOAD:
            begin
                // write back the previous operation
                if (op_reg != OP_LOW)
                begin
                    case (post_op)
                        OP_LOW:  low_s_next      = sat_state(x_p + rnd_f);
                        OP_MID:  mid_s_next      = sat_state(x_p + rnd_f);
                        OP_ENVL: sum_next        = rnd_f[SUM_W-1:0];
                        OP_DARK: dark_s_next     = sat_state(high_raw_p + rnd_f);
                        OP_ENVM: sum_next        = sum_reg + rnd_f[SUM_W-1:0];
                        OP_GEOL: env_low_next    = geo_val;
                        OP_ENVH: sum_next        = sum_reg + rnd_f[SUM_W-1:0];
                        OP_GEOM: env_mid_next    = geo_val;
                        OP_GEOH: env_high_next   = geo_val;
                        OP_GEOD: dark_coeff_next = geo_val;
                        default: ;
                    endcase
                end

                // load operands for this operation
                case (op_reg)
                    OP_LOW:
                    begin
                        a_next = A_W'(low_s_reg) - A_W'(x_reg);
                        b_next = clamp_unity(low_coeff_reg);
                    end
                    OP_MID:
                    begin
                        a_next = A_W'(mid_s_reg) - A_W'(x_reg);
                        b_next = clamp_unity(mid_coeff_reg);
                    end
                    OP_ENVL:
                    begin
                        a_next = A_W'(low_s_reg);
                        b_next = env_low_reg;
                    end
                    OP_DARK:
                    begin
                        a_next = A_W'(dark_s_reg) - A_W'(high_raw_p);
                        b_next = dark_coeff_reg;
                    end
                    OP_ENVM:
                    begin
                        a_next = A_W'(mid_s_reg) - A_W'(low_s_reg);
                        b_next = env_mid_reg;
                    end
                    OP_GEOL:
                    begin
                        a_next = A_W'(env_low_reg);
                        b_next = low_decay_ratio_reg;
                    end
                    OP_ENVH:
                    begin
                        a_next = A_W'(dark_s_reg);
                        b_next = env_high_reg;
                    end
                    OP_GEOM:
                    begin
                        a_next = A_W'(env_mid_reg);
                        b_next = mid_decay_ratio_reg;
                    end
                    OP_GEOH:
                    begin
                        a_next = A_W'(env_high_reg);
                        b_next = high_decay_ratio_reg;
                    end
                    OP_GEOD:
                    begin
                        a_next = A_W'(dark_coeff_reg);
                        b_next = high_coeff_ratio_reg;
                    end
                    OP_GAIN:
                    begin
                        a_next = A_W'(sum_clamped);
                        b_next = clamp_unity(late_gain_reg);
                    end
                    default: ;
                endcase
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                if (op_reg == OP_GAIN)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    op_next    = op_t'(op_reg + 4'd1);
                    state_next = ST_LOAD;
                end
            end

            ST_DONE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    if (rnd_g > SMP_MAX)
                    begin
                        tail_next = SMP_MAX[SAMPLE_BITS-1:0];
                    end
                    else if (rnd_g < SMP_MIN)
                    begin
                        tail_next = SMP_MIN[SAMPLE_BITS-1:0];
                    end
                    else
                    begin
                        tail_next = rnd_g[SAMPLE_BITS-1:0];
                    end
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            op_reg               <= OP_LOW;
            low_coeff_reg        <= '0;
            mid_coeff_reg        <= '0;
            high_coeff_start_reg <= '0;
            high_coeff_ratio_reg <= UNITY;
            low_decay_ratio_reg  <= UNITY;
            mid_decay_ratio_reg  <= UNITY;
            high_decay_ratio_reg <= UNITY;
            late_gain_reg        <= UNITY;
            low_s_reg            <= '0;
            mid_s_reg            <= '0;
            dark_s_reg           <= '0;
            dark_coeff_reg       <= '0;
            env_low_reg          <= UNITY;
            env_mid_reg          <= UNITY;
            env_high_reg         <= UNITY;
            sum_reg              <= '0;
            tail_reg             <= '0;
            m_tvalid_reg         <= 1'b0;
        end
        else
        begin
            state_reg            <= state_next;
            op_reg               <= op_next;
            low_coeff_reg        <= low_coeff_next;
            mid_coeff_reg        <= mid_coeff_next;
            high_coeff_start_reg <= high_coeff_start_next;
            high_coeff_ratio_reg <= high_coeff_ratio_next;
            low_decay_ratio_reg  <= low_decay_ratio_next;
            mid_decay_ratio_reg  <= mid_decay_ratio_next;
            high_decay_ratio_reg <= high_decay_ratio_next;
            late_gain_reg        <= late_gain_next;
            low_s_reg            <= low_s_next;
            mid_s_reg            <= mid_s_next;
            dark_s_reg           <= dark_s_next;
            dark_coeff_reg       <= dark_coeff_next;
            env_low_reg          <= env_low_next;
            env_mid_reg          <= env_mid_next;
            env_high_reg         <= env_high_next;
            sum_reg              <= sum_next;
            tail_reg             <= tail_next;
            m_tvalid_reg         <= m_tvalid_next;
        end
    end

    // shared multiplier and its operand registers
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        a_reg <= a_next;
        b_reg <= b_next;
        if (state_reg == ST_MUL)
        begin
            prod_reg <= a_reg * $signed({1'b0, b_reg});
        end
    end

endmodule
